>>> src/assert_macros.svh
// assertion helpers, sampled on clk and switched off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define AST_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/shdcs_pkg.sv
`default_nettype none

package shdcs_pkg;

  localparam int unsigned QDEPTH = 4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    ACT_CHAR  = 2'd0,
    ACT_EOL   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BLOCK  = 2'd1,
    MODE_LINE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_SLASH = 2'd1,
    HOLD_STAR  = 2'd2,
    HOLD_DASH  = 2'd3
  } hold_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_ch;
    logic       is_line_end;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    mode_e mode;
    hold_e pending;
    logic  emitted_any;
    logic  token_seen;
  } state_t;

  typedef struct packed {
    state_t     nxt;
    out_beat_t  r0;
    out_beat_t  r1;
    logic [1:0] cnt;
  } step_t;

  localparam state_t ST_RESET = '{
    mode:        MODE_NORMAL,
    pending:     HOLD_NONE,
    emitted_any: 1'b0,
    token_seen:  1'b0
  };

  function automatic hold_e starter(input logic [7:0] c);
    hold_e h;
    h = HOLD_NONE;
    if (c == CH_SLASH) begin
      h = HOLD_SLASH;
    end else if (c == CH_STAR) begin
      h = HOLD_STAR;
    end else if (c == CH_DASH) begin
      h = HOLD_DASH;
    end
    return h;
  endfunction

  function automatic logic [7:0] hold_char(input hold_e h);
    logic [7:0] b;
    unique case (h)
      HOLD_SLASH: b = CH_SLASH;
      HOLD_STAR:  b = CH_STAR;
      HOLD_DASH:  b = CH_DASH;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/shdcs_step.sv
`default_nettype none

module shdcs_step (
  input  shdcs_pkg::state_t   cur,
  input  shdcs_pkg::in_beat_t beat,
  output shdcs_pkg::step_t    step
);
  import shdcs_pkg::*;

  logic       in_blk;
  logic       in_line;
  logic       tok_open;
  logic       tok_line;
  logic       tok_close;
  logic       tok;
  hold_e      start;
  logic       hold_out;
  logic       char_out;
  logic       eol_out;
  logic       second;
  logic [7:0] b2;

  always_comb begin
    in_blk    = (cur.mode == MODE_BLOCK);
    in_line   = (cur.mode == MODE_LINE);
    tok_open  = (cur.pending == HOLD_SLASH) && (beat.ch == CH_STAR);
    tok_line  = ((cur.pending == HOLD_SLASH) && (beat.ch == CH_SLASH)) ||
                ((cur.pending == HOLD_DASH) && (beat.ch == CH_DASH));
    tok_close = (cur.pending == HOLD_STAR) && (beat.ch == CH_SLASH);
    tok       = tok_open || tok_line || tok_close;
    start     = starter(beat.ch);

    step.nxt  = cur;
    step.r0   = '0;
    step.r1   = '0;
    step.cnt  = 2'd0;
    hold_out  = 1'b0;
    char_out  = 1'b0;
    eol_out   = 1'b0;

    unique case (beat.action)
      ACT_CHAR: begin
        if (!in_line) begin
          if (tok) begin
            step.nxt.pending    = HOLD_NONE;
            step.nxt.token_seen = 1'b1;
            if (in_blk) begin
              if (tok_close) begin
                step.nxt.mode = MODE_NORMAL;
              end
            end else if (tok_open) begin
              step.nxt.mode = MODE_BLOCK;
            end else if (tok_line) begin
              step.nxt.mode = MODE_LINE;
            end
          end else begin
            hold_out         = (cur.pending != HOLD_NONE) && !in_blk;
            char_out         = (start == HOLD_NONE) && !in_blk;
            step.nxt.pending = start;
            if (hold_out || char_out) begin
              step.nxt.emitted_any = 1'b1;
            end
          end
        end
      end
      ACT_EOL: begin
        hold_out = (cur.pending != HOLD_NONE) && !in_blk && !in_line;
        eol_out  = hold_out || cur.emitted_any || (!cur.token_seen && !in_blk);
        step.nxt.pending     = HOLD_NONE;
        step.nxt.emitted_any = 1'b0;
        step.nxt.token_seen  = 1'b0;
        if (in_line) begin
          step.nxt.mode = MODE_NORMAL;
        end
      end
      ACT_CLEAR: begin
        step.nxt = ST_RESET;
      end
      default: begin
      end
    endcase

    // held start goes first, then the new byte or the line end
    second = char_out || eol_out;
    b2     = char_out ? beat.ch : 8'h00;

    if (hold_out) begin
      step.r0 = '{out_ch: hold_char(cur.pending), is_line_end: 1'b0, last: !second};
      if (second) begin
        step.r1  = '{out_ch: b2, is_line_end: eol_out, last: 1'b1};
        step.cnt = 2'd2;
      end else begin
        step.cnt = 2'd1;
      end
    end else if (second) begin
      step.r0  = '{out_ch: b2, is_line_end: eol_out, last: 1'b1};
      step.cnt = 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> src/shader_comment_stripper_core.sv
// channel   valid        stall        beat
// text      text_valid   text_stall   text  (action, ch)
// strip     strip_valid  strip_stall  strip (out_ch, is_line_end, last)
//
// one text beat per cycle is taken into an input register while text_stall is low;
// from there the decode writes zero to two strip beats into a four-entry queue
// the queue drains one strip beat per cycle while strip_stall is low, which bounds
// the rate when beats yield more than one result on average
// rst is synchronous: comment state, input register and queue are emptied
// text_stall rises only while the input register holds a beat and the
// queue has fewer than two free entries
`default_nettype none

`include "assert_macros.svh"

module shader_comment_stripper_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  shdcs_pkg::in_beat_t  text,
  output logic                 strip_valid,
  input  logic                 strip_stall,
  output shdcs_pkg::out_beat_t strip
);
  import shdcs_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  in_beat_t  in_q;
  logic      in_vld;
  state_t    state;
  step_t     step;

  out_beat_t       queue [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;

  logic accept;
  logic room;
  logic advance;
  logic pop;

  shdcs_step u_step (
    .cur  (state),
    .beat (in_q),
    .step (step)
  );

  assign room        = (count <= CW'(QDEPTH - 2));
  assign advance     = in_vld && room;
  assign text_stall  = in_vld && !room;
  assign accept      = text_valid && !text_stall;
  assign strip_valid = (count != '0);
  assign strip       = queue[rd_ptr];
  assign pop         = strip_valid && !strip_stall;

  always_comb begin
    count_next = count;
    if (advance) begin
      count_next = count_next + CW'(step.cnt);
    end
    if (pop) begin
      count_next = count_next - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
    end else if (advance) begin
      state <= step.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (advance) begin
        wr_ptr <= wr_ptr + PW'(step.cnt);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (step.cnt != 2'd0)) begin
      queue[wr_ptr] <= step.r0;
    end
    if (advance && (step.cnt == 2'd2)) begin
      queue[wr_ptr + PW'(1)] <= step.r1;
    end
  end

  `AST_ALWAYS(a_count_max, count <= CW'(QDEPTH))
  `AST_IMPLIES(a_line_end_zero, strip_valid && strip.is_line_end, strip.out_ch == 8'h00)
  `AST_NEXT(a_clear_state, advance && (in_q.action == ACT_CLEAR), state == ST_RESET)
  `AST_NEXT(a_pop_only, pop && !advance, count == $past(count) - CW'(1))

endmodule

`default_nettype wire
